>>> rtl/cfe_pkg.sv
// Package: actions, statuses, sequencer states and constants of the cuckoo filter engine.
package cfe_pkg;

  localparam logic [63:0] MM_M = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] ALT_SEED = 64'h0000_0000_9747_b28c;
  localparam logic [63:0] H_INIT = ALT_SEED ^ (MM_M << 3);
  localparam logic [12:0] TALLY_MAX = 13'd8191;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [1:0] CFG_LOG2 = 2'd0;
  localparam logic [1:0] CFG_SLOTS = 2'd1;
  localparam logic [1:0] CFG_KICKS = 2'd2;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_INSERT_UNIQUE = 3'd1,
    ACT_CONTAINS = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_COUNT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_EXISTS = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MOP_MUL = 2'd0,
    MOP_XSHIFT = 2'd1,
    MOP_XOR_H = 2'd2
  } mop_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD1,
    S_CHK1,
    S_RD2,
    S_CHK2,
    S_KICK_MOD,
    S_KICK_RD,
    S_KICK_WR,
    S_KICK_HASH,
    S_KICK_CHK,
    S_OUT
  } state_t;

endpackage

>>> rtl/cfe_mix.sv
// Module: shared 64-bit multiply, shift-xor unit used for the MurmurHash64A rounds.
module cfe_mix (
  input  logic clk,
  input  logic start,
  input  logic [63:0] key,
  output logic busy,
  output logic [63:0] result
);
  import cfe_pkg::*;

  // Program: k*=M; k^=k>>47; k*=M; h^=k; h*=M; h^=h>>47; h*=M; h^=h>>47
  // The 64x64 multiply is split into 32x32 partial products, one per cycle.
  logic [63:0] k;
  logic [63:0] h;
  logic [3:0] step;
  logic [1:0] part;
  logic [63:0] acc;
  logic [31:0] pa;
  logic [31:0] pb;
  logic [63:0] prod;
  logic [63:0] src;

  assign result = h;
  assign src = (step == 4'd0 || step == 4'd2) ? k : h;

  always_comb begin
    case (part)
      2'd0: begin pa = src[31:0]; pb = MM_M[31:0]; end
      2'd1: begin pa = src[31:0]; pb = MM_M[63:32]; end
      default: begin pa = src[63:32]; pb = MM_M[31:0]; end
    endcase
    prod = {32'd0, pa} * {32'd0, pb};
  end

  function automatic mop_t op_of(input logic [3:0] s);
    case (s)
      4'd0, 4'd2, 4'd4, 4'd6: op_of = MOP_MUL;
      4'd3: op_of = MOP_XOR_H;
      default: op_of = MOP_XSHIFT;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (start) begin
      k <= key;
      h <= H_INIT;
      step <= 4'd0;
      part <= 2'd0;
      busy <= 1'b1;
    end else if (busy) begin
      case (op_of(step))
        MOP_MUL: begin
          if (part == 2'd0) begin
            acc <= prod;
            part <= 2'd1;
          end else if (part == 2'd1) begin
            acc <= acc + {prod[31:0], 32'd0};
            part <= 2'd2;
          end else begin
            if (step == 4'd0 || step == 4'd2) k <= acc + {prod[31:0], 32'd0};
            else h <= acc + {prod[31:0], 32'd0};
            part <= 2'd0;
            step <= step + 4'd1;
          end
        end
        MOP_XOR_H: begin
          h <= h ^ k;
          step <= step + 4'd1;
        end
        default: begin
          if (step == 4'd1) k <= k ^ (k >> 47);
          else h <= h ^ (h >> 47);
          if (step == 4'd7) busy <= 1'b0;
          step <= step + 4'd1;
        end
      endcase
    end
  end
endmodule

>>> rtl/cuckoo_filter_engine.sv
// Top level: cuckoo filter engine with a bucket memory and a sequencer over a shared hash unit.
// Each hash is four 64x64 multiplies at three 32x32 partial products each and four shift or xor
// steps; bucket two is read unless an insert or remove is settled in bucket one.
// Each kick takes the victim remainder, a read, a write, a hash and a check.
// One word at a time: s_tready is high only in idle, so a new word waits for the last result.
// Reset: synchronous; a clearing pass over all 2**BUCKETS_LOG2 buckets zeroes the bucket memory first.
module cuckoo_filter_engine #(
  parameter int BUCKETS_LOG2 = 10,
  parameter int BUCKET_SLOTS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [71:0] s_tdata,   // action[2:0], key_hash[66:3], zero fill
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata,   // status[1:0], occurrences[5:2], stored_items[18:6], zero fill
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);
  import cfe_pkg::*;

  localparam int NB = 1 << BUCKETS_LOG2;
  localparam int BW = BUCKET_SLOTS * 8;
  localparam int SW = $clog2(BUCKET_SLOTS + 1);
  localparam int VW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;

  logic [BW-1:0] mem [NB];
  logic [BW-1:0] rdata;
  logic [BUCKETS_LOG2-1:0] raddr;
  logic [BUCKETS_LOG2-1:0] waddr;
  logic [BW-1:0] wdata;
  logic we;

  // Configuration registers.
  logic [3:0] cfg_log2;
  logic [2:0] cfg_slots;
  logic [9:0] cfg_kicks;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_log2 <= 4'd10;
      cfg_slots <= 3'd4;
      cfg_kicks <= 10'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOG2: cfg_log2 <= cfg_data[3:0];
        CFG_SLOTS: cfg_slots <= cfg_data[2:0];
        CFG_KICKS: cfg_kicks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective mask and slot count.
  logic [BUCKETS_LOG2-1:0] bmask;
  logic [SW-1:0] nslots;
  always_comb begin
    bmask = '0;
    for (int i = 0; i < BUCKETS_LOG2; i++) bmask[i] = (32'(cfg_log2) > i);
    if (cfg_slots == 3'd0) nslots = SW'(1);
    else if (32'(cfg_slots) > BUCKET_SLOTS) nslots = SW'(BUCKET_SLOTS);
    else nslots = SW'(cfg_slots);
  end

  state_t state, state_next;
  logic [2:0] act;
  logic [63:0] hash;
  logic [7:0] fp;
  logic [7:0] carry;
  logic [BUCKETS_LOG2-1:0] b1, b2, cur, clr;
  logic [9:0] kicks;
  logic [3:0] occ;
  logic [12:0] tally;
  logic [15:0] lfsr;
  logic [1:0] status;
  logic [VW-1:0] victim;
  logic hstart;
  logic hbusy;
  logic [63:0] hres;
  logic [63:0] hkey;
  logic hwait;

  cfe_mix u_mix (
    .clk(clk), .start(hstart), .key(hkey), .busy(hbusy), .result(hres)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Per-bucket scans over the read word.
  logic [3:0] match_cnt;
  logic has_empty, has_match;
  logic [VW-1:0] empty_idx, match_idx;
  always_comb begin
    match_cnt = '0;
    has_empty = 1'b0;
    has_match = 1'b0;
    empty_idx = '0;
    match_idx = '0;
    for (int j = BUCKET_SLOTS - 1; j >= 0; j--) begin
      if (j < 32'(nslots)) begin
        if (rdata[j*8 +: 8] == 8'd0) begin has_empty = 1'b1; empty_idx = VW'(j); end
        if (rdata[j*8 +: 8] == fp) begin
          has_match = 1'b1;
          match_idx = VW'(j);
          match_cnt = match_cnt + 4'd1;
        end
      end
    end
  end

  logic [15:0] lfsr_adv;
  assign lfsr_adv = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  // Victim slot is the advanced LFSR mod the slot count: one remainder bit per cycle,
  // most significant first, with a compare and subtract against the slot count.
  logic [3:0] mcnt;
  logic [2:0] mrem;
  logic [3:0] mod_try;
  logic [3:0] mod_sub;
  assign mod_try = {mrem, lfsr_adv[4'd15 - mcnt]};
  assign mod_sub = (mod_try >= 4'(nslots)) ? mod_try - 4'(nslots) : mod_try;

  logic [4:0] occ_sum;
  assign occ_sum = {1'b0, occ} + {1'b0, match_cnt};

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    hstart = 1'b0;
    hkey = hash | {24'd0, fp, 32'd0};
    raddr = b1;
    we = 1'b0;
    waddr = clr;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (clr == BUCKETS_LOG2'(NB - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_HASH;
      end
      S_HASH: begin
        hstart = !hwait;
        if (hwait && !hbusy) state_next = S_RD1;
      end
      S_RD1: begin raddr = b1; state_next = S_CHK1; end
      S_CHK1: begin
        raddr = b2;
        if (act == ACT_INSERT) begin
          if (has_empty) begin
            we = 1'b1; waddr = b1; wdata = rdata;
            wdata[empty_idx*8 +: 8] = fp;
            state_next = S_OUT;
          end else state_next = S_RD2;
        end else if (act == ACT_REMOVE && has_match) begin
          we = 1'b1; waddr = b1; wdata = rdata;
          wdata[match_idx*8 +: 8] = 8'd0;
          state_next = S_OUT;
        end else if (act inside {ACT_INSERT_UNIQUE, ACT_CONTAINS, ACT_COUNT, ACT_REMOVE}) begin
          state_next = S_RD2;
        end else state_next = S_OUT;
      end
      S_RD2: begin raddr = b2; state_next = S_CHK2; end
      S_CHK2: begin
        raddr = b1;
        state_next = S_OUT;
        if (act == ACT_INSERT) begin
          if (has_empty) begin
            we = 1'b1; waddr = b2; wdata = rdata;
            wdata[empty_idx*8 +: 8] = fp;
          end else if (cfg_kicks != 10'd0) state_next = S_KICK_MOD;
        end else if (act == ACT_REMOVE && has_match) begin
          we = 1'b1; waddr = b2; wdata = rdata;
          wdata[match_idx*8 +: 8] = 8'd0;
        end else if (act == ACT_INSERT_UNIQUE && occ == 4'd0 && !has_match) begin
          state_next = S_RD1;
        end
      end
      S_KICK_MOD: if (mcnt == 4'd15) state_next = S_KICK_RD;
      S_KICK_RD: begin raddr = cur; state_next = S_KICK_WR; end
      S_KICK_WR: begin
        we = 1'b1; waddr = cur; wdata = rdata;
        wdata[victim*8 +: 8] = carry;
        state_next = S_KICK_HASH;
      end
      S_KICK_HASH: begin
        hkey = {24'd0, carry, 32'(cur)};
        hstart = !hwait;
        raddr = hres[BUCKETS_LOG2-1:0] & bmask;
        if (hwait && !hbusy) state_next = S_KICK_CHK;
      end
      S_KICK_CHK: begin
        raddr = cur;
        if (has_empty) begin
          we = 1'b1; waddr = cur; wdata = rdata;
          wdata[empty_idx*8 +: 8] = carry;
          state_next = S_OUT;
        end else if (kicks == cfg_kicks) state_next = S_OUT;
        else state_next = S_KICK_MOD;
      end
      S_OUT: if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {5'd0, tally, occ, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      tally <= '0;
      lfsr <= LFSR_SEED;
      hwait <= 1'b0;
      mcnt <= '0;
      mrem <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      hwait <= hstart ? 1'b1 : (hbusy ? hwait : 1'b0);
      case (state)
        S_IDLE: if (s_tvalid) begin
          act <= s_tdata[2:0];
          hash <= s_tdata[66:3];
          fp <= s_tdata[26:19] + 8'd1;
          b1 <= s_tdata[BUCKETS_LOG2+2:3] & bmask;
          occ <= '0;
          status <= ST_DONE;
          kicks <= '0;
        end
        S_HASH: if (hwait && !hbusy) b2 <= hres[BUCKETS_LOG2-1:0] & bmask;
        S_CHK1: begin
          if (act inside {ACT_INSERT_UNIQUE, ACT_CONTAINS, ACT_COUNT}) occ <= match_cnt;
          if (act == ACT_INSERT && has_empty && tally != TALLY_MAX) tally <= tally + 13'd1;
          if (act == ACT_REMOVE && has_match && tally != 13'd0) tally <= tally - 13'd1;
          if (!(act inside {ACT_INSERT, ACT_INSERT_UNIQUE, ACT_CONTAINS, ACT_COUNT,
                            ACT_REMOVE})) status <= ST_DONE;
        end
        S_CHK2: begin
          cur <= b1;
          carry <= fp;
          // Only count reports occurrences; drop the partial sum for every other action.
          occ <= (act == ACT_COUNT) ? ((occ_sum > 5'd15) ? 4'd15 : occ_sum[3:0]) : 4'd0;
          case (act)
            ACT_INSERT: begin
              if (has_empty) begin
                if (tally != TALLY_MAX) tally <= tally + 13'd1;
              end else status <= ST_NO_SPACE;
            end
            ACT_INSERT_UNIQUE: begin
              if (occ != 4'd0 || has_match) status <= ST_EXISTS;
              else act <= ACT_INSERT;
            end
            ACT_CONTAINS: begin
              status <= (occ != 4'd0 || has_match) ? ST_DONE : ST_NOT_FOUND;
            end
            ACT_REMOVE: begin
              if (has_match) begin
                if (tally != 13'd0) tally <= tally - 13'd1;
              end else status <= ST_NOT_FOUND;
            end
            ACT_COUNT: status <= (occ_sum != 5'd0) ? ST_DONE : ST_NOT_FOUND;
            default: ;
          endcase
        end
        S_KICK_MOD: begin
          mcnt <= mcnt + 4'd1;
          if (mcnt == 4'd15) begin
            mrem <= '0;
            victim <= VW'(mod_sub);
            lfsr <= lfsr_adv;
          end else mrem <= mod_sub[2:0];
        end
        S_KICK_WR: begin
          carry <= rdata[victim*8 +: 8];
          kicks <= kicks + 10'd1;
        end
        S_KICK_HASH: if (hwait && !hbusy) cur <= hres[BUCKETS_LOG2-1:0] & bmask;
        S_KICK_CHK: begin
          if (has_empty) begin
            status <= ST_DONE;
            if (tally != TALLY_MAX) tally <= tally + 13'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
